// ===== sv/rbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray/box intersection package
// Shared widths, payload structs, register indexes and helper functions.
// ----------------------------------------------------------------------------
package rbi_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   // Dividend of the plane distance: (plane - origin) << FRAC_BITS.
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int NUM_WIDTH   = DIFF_WIDTH + FRAC_BITS;
   localparam int QUO_WIDTH   = NUM_WIDTH;
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH - FRAC_BITS + 1;
   localparam int DIV_STEPS   = QUO_WIDTH;
   localparam int AXES        = 3;
   localparam int CSR_IDX_WIDTH = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_BOX_LOW_X  = 3'd0,
      CSR_BOX_LOW_Y  = 3'd1,
      CSR_BOX_LOW_Z  = 3'd2,
      CSR_BOX_HIGH_X = 3'd3,
      CSR_BOX_HIGH_Y = 3'd4,
      CSR_BOX_HIGH_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      coord_type origin_x;
      coord_type origin_y;
      coord_type origin_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } req_type;

   typedef struct packed {
      logic      hit;
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
   } rsp_type;

   typedef struct packed {
      coord_type [AXES-1:0] low;
      coord_type [AXES-1:0] high;
   } box_type;

   // Per-axis classification carried down the pipeline.
   typedef struct packed {
      logic      cand;    // origin outside the slab on this axis
      logic      dir_nz;
      coord_type org;
      coord_type dir;
      coord_type plane;
   } axis_type;

   localparam coord_type MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type NEG_ONE = -(coord_type'(1) <<< FRAC_BITS);

   // Saturate a wide signed quotient to the coordinate range.
   function automatic coord_type sat_coord(input logic signed [QUO_WIDTH-1:0] v);
      coord_type r;
      if (v > QUO_WIDTH'(signed'(MAX_VAL)))
         r = MAX_VAL;
      else if (v < QUO_WIDTH'(signed'(MIN_VAL)))
         r = MIN_VAL;
      else
         r = v[COORD_WIDTH-1:0];
      return r;
   endfunction

endpackage

// ===== sv/rbi_divider.sv =====
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division, one quotient bit per stage, truncating toward zero.
// The divisor magnitude and the result sign travel alongside through every stage.
// ----------------------------------------------------------------------------
module rbi_divider import rbi_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [NUM_WIDTH-1:0]   in_num,
   input  coord_type                     in_den,
   output logic                          out_valid,
   output logic signed [QUO_WIDTH-1:0]   out_quo
);

   localparam int REM_WIDTH = COORD_WIDTH + 1;

   logic [DIV_STEPS:0]                   valid_ff;
   logic [DIV_STEPS:0][NUM_WIDTH-1:0]    dvd_ff;    // remaining dividend bits / quotient
   logic [DIV_STEPS:0][REM_WIDTH-1:0]    rem_ff;
   logic [DIV_STEPS:0][COORD_WIDTH-1:0]  den_ff;    // divisor magnitude
   logic [DIV_STEPS:0]                   neg_ff;

   logic [NUM_WIDTH-1:0]   num_mag;
   logic [COORD_WIDTH-1:0] den_mag;

   assign num_mag = in_num[NUM_WIDTH-1] ? NUM_WIDTH'(-in_num) : in_num;
   assign den_mag = in_den[COORD_WIDTH-1] ? COORD_WIDTH'(-in_den) : in_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      dvd_ff[0] <= num_mag;
      rem_ff[0] <= '0;
      den_ff[0] <= den_mag;
      neg_ff[0] <= in_num[NUM_WIDTH-1] ^ in_den[COORD_WIDTH-1];
   end

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [REM_WIDTH-1:0] trial;
      logic [REM_WIDTH:0]   diff;
      assign trial = {rem_ff[s][REM_WIDTH-2:0], dvd_ff[s][NUM_WIDTH-1]};
      assign diff  = {1'b0, trial} - {2'b0, den_ff[s]};
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         if (!diff[REM_WIDTH]) begin
            rem_ff[s+1] <= diff[REM_WIDTH-1:0];
            dvd_ff[s+1] <= {dvd_ff[s][NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= trial;
            dvd_ff[s+1] <= {dvd_ff[s][NUM_WIDTH-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS];
   assign out_quo   = neg_ff[DIV_STEPS] ? QUO_WIDTH'(-signed'(dvd_ff[DIV_STEPS]))
                                        : signed'(dvd_ff[DIV_STEPS]);

endmodule

// ===== sv/rbi_delay.sv =====
// ----------------------------------------------------------------------------
// Ray/box delay line
// Carries the per-axis classification alongside the dividers.
// ----------------------------------------------------------------------------
module rbi_delay import rbi_pkg::*; (
   input  logic                  clock,
   input  axis_type [AXES-1:0]   in_axes,
   input  logic                  in_inside,
   output axis_type [AXES-1:0]   out_axes,
   output logic                  out_inside
);

   localparam int DEPTH = DIV_STEPS + 1;

   axis_type [DEPTH-1:0][AXES-1:0] axes_ff;
   logic     [DEPTH-1:0]           inside_ff;

   always_ff @(posedge clock) begin
      axes_ff[0]   <= in_axes;
      inside_ff[0] <= in_inside;
      for (int i = 1; i < DEPTH; i++) begin
         axes_ff[i]   <= axes_ff[i-1];
         inside_ff[i] <= inside_ff[i-1];
      end
   end

   assign out_axes   = axes_ff[DEPTH-1];
   assign out_inside = inside_ff[DEPTH-1];

endmodule

// ===== sv/ray_box_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// Ray/box intersection unit
// Tests one Q16.16 ray per clock against a box held in control registers.
// ----------------------------------------------------------------------------
// A ray transaction is taken at every clock edge with start high and busy
// low; busy is always low, so one ray can enter each cycle. The result is
// shown on the rsp_ ports, marked by rsp_valid for a single cycle, once the
// ray has passed the input, classification, divider, saturation, selection,
// product and result registers. The receiver cannot stall the unit, so every
// result must be taken when it is shown. Most of the depth lies in the three
// plane-distance dividers, which produce one quotient bit per pipeline stage.
// Box registers should be written only while no ray is in flight.

module ray_box_intersection_unit import rbi_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  coord_type                 csr_wdata
);

   box_type box_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Control registers; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BOX_LOW_X:  box_ff.low[0]  <= csr_wdata;
            CSR_BOX_LOW_Y:  box_ff.low[1]  <= csr_wdata;
            CSR_BOX_LOW_Z:  box_ff.low[2]  <= csr_wdata;
            CSR_BOX_HIGH_X: box_ff.high[0] <= csr_wdata;
            CSR_BOX_HIGH_Y: box_ff.high[1] <= csr_wdata;
            CSR_BOX_HIGH_Z: box_ff.high[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: register the ray.
   logic    s1_valid_ff;
   req_type s1_req_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_req_ff <= req_data;
   end

   // Stage 2: classify each axis against the slab.
   coord_type [AXES-1:0] org, dir;
   assign org = {s1_req_ff.origin_z, s1_req_ff.origin_y, s1_req_ff.origin_x};
   assign dir = {s1_req_ff.dir_z, s1_req_ff.dir_y, s1_req_ff.dir_x};

   axis_type [AXES-1:0] s2_axes_in, s2_axes_ff;
   logic                s2_inside_in, s2_inside_ff, s2_valid_ff;

   always_comb begin
      s2_inside_in = 1'b1;
      for (int a = 0; a < AXES; a++) begin
         s2_axes_in[a].org    = org[a];
         s2_axes_in[a].dir    = dir[a];
         s2_axes_in[a].dir_nz = |dir[a];
         s2_axes_in[a].cand   = 1'b1;
         s2_axes_in[a].plane  = '0;
         if (org[a] < box_ff.low[a]) begin
            s2_axes_in[a].plane = box_ff.low[a];
            s2_inside_in = 1'b0;
         end else if (org[a] > box_ff.high[a]) begin
            s2_axes_in[a].plane = box_ff.high[a];
            s2_inside_in = 1'b0;
         end else begin
            s2_axes_in[a].cand = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_axes_ff   <= s2_axes_in;
      s2_inside_ff <= s2_inside_in;
   end

   // Divider stages: t = ((plane - origin) << FRAC_BITS) / dir per axis.
   logic [AXES-1:0]                     div_valid;
   logic [AXES-1:0][QUO_WIDTH-1:0]      div_quo;
   for (genvar a = 0; a < AXES; a++) begin : g_div
      logic signed [DIFF_WIDTH-1:0] diff;
      logic signed [NUM_WIDTH-1:0]  num;
      coord_type                    den;
      assign diff = DIFF_WIDTH'(s2_axes_ff[a].plane) - DIFF_WIDTH'(s2_axes_ff[a].org);
      assign num  = NUM_WIDTH'(diff) <<< FRAC_BITS;
      // A zero divisor is replaced by one; the quotient is discarded anyway.
      assign den  = s2_axes_ff[a].dir_nz ? s2_axes_ff[a].dir : coord_type'(1);
      rbi_divider u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (s2_valid_ff),
         .in_num    (num),
         .in_den    (den),
         .out_valid (div_valid[a]),
         .out_quo   (div_quo[a])
      );
   end

   axis_type [AXES-1:0] d_axes;
   logic                d_inside;
   rbi_delay u_delay (
      .clock      (clock),
      .in_axes    (s2_axes_ff),
      .in_inside  (s2_inside_ff),
      .out_axes   (d_axes),
      .out_inside (d_inside)
   );

   // Stage 3: saturate and substitute -1.0 for axes without a candidate plane or with a zero direction.
   logic                  s3_valid_ff, s3_inside_ff;
   coord_type [AXES-1:0]  s3_t_ff;
   axis_type  [AXES-1:0]  s3_axes_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= div_valid[0];
      end
      for (int a = 0; a < AXES; a++) begin
         s3_t_ff[a] <= (d_axes[a].cand && d_axes[a].dir_nz) ?
                       sat_coord(signed'(div_quo[a])) : NEG_ONE;
      end
      s3_axes_ff   <= d_axes;
      s3_inside_ff <= d_inside;
   end

   // Stage 4: pick the largest distance, lowest axis on ties.
   logic                  s4_valid_ff, s4_inside_ff;
   logic [1:0]            s4_best_in, s4_best_ff;
   coord_type             s4_tmax_in, s4_tmax_ff;
   axis_type  [AXES-1:0]  s4_axes_ff;
   always_comb begin
      s4_best_in = 2'd0;
      s4_tmax_in = s3_t_ff[0];
      if (s4_tmax_in < s3_t_ff[1]) begin
         s4_best_in = 2'd1;
         s4_tmax_in = s3_t_ff[1];
      end
      if (s4_tmax_in < s3_t_ff[2]) begin
         s4_best_in = 2'd2;
         s4_tmax_in = s3_t_ff[2];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_best_ff   <= s4_best_in;
      s4_tmax_ff   <= s4_tmax_in;
      s4_axes_ff   <= s3_axes_ff;
      s4_inside_ff <= s3_inside_ff;
   end

   // Stage 5: one 32x32 product per axis.
   logic                                s5_valid_ff, s5_inside_ff, s5_neg_ff;
   logic [1:0]                          s5_best_ff;
   logic signed [AXES-1:0][PROD_WIDTH-1:0] s5_prod_ff;
   axis_type  [AXES-1:0]                s5_axes_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      for (int a = 0; a < AXES; a++) begin
         s5_prod_ff[a] <= PROD_WIDTH'(s4_tmax_ff) * PROD_WIDTH'(s4_axes_ff[a].dir);
      end
      s5_neg_ff    <= s4_tmax_ff[COORD_WIDTH-1];
      s5_best_ff   <= s4_best_ff;
      s5_axes_ff   <= s4_axes_ff;
      s5_inside_ff <= s4_inside_ff;
   end

   // Stage 6: hit coordinates, box test, result register.
   rsp_type              rsp_in, rsp_ff;
   logic                 rsp_valid_ff;
   coord_type [AXES-1:0] pt;
   logic                 ok;
   always_comb begin
      logic signed [SUM_WIDTH-1:0] sum;
      ok = !s5_neg_ff;
      for (int a = 0; a < AXES; a++) begin
         // Elements of the product array are unsigned, so the shift needs
         // a signed view to round toward minus infinity.
         sum = SUM_WIDTH'(s5_axes_ff[a].org)
             + SUM_WIDTH'(signed'(s5_prod_ff[a]) >>> FRAC_BITS);
         if (2'(a) == s5_best_ff) begin
            pt[a] = s5_axes_ff[a].plane;
         end else begin
            pt[a] = sum[COORD_WIDTH-1:0];
            if (sum < SUM_WIDTH'(box_ff.low[a]) || sum > SUM_WIDTH'(box_ff.high[a]))
               ok = 1'b0;
         end
      end
      rsp_in = '0;
      if (s5_inside_ff) begin
         rsp_in.hit     = 1'b1;
         rsp_in.point_x = s5_axes_ff[0].org;
         rsp_in.point_y = s5_axes_ff[1].org;
         rsp_in.point_z = s5_axes_ff[2].org;
      end else if (ok) begin
         rsp_in.hit     = 1'b1;
         rsp_in.point_x = pt[0];
         rsp_in.point_y = pt[1];
         rsp_in.point_z = pt[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s5_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/rbi_checker.sv =====
// ----------------------------------------------------------------------------
// Ray/box intersection checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rbi_checker import rbi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  logic    rsp_valid,
   input  rsp_type rsp_data
);

   localparam int LATENCY = DIV_STEPS + 7;

   // Every accepted transaction yields exactly one result after the latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after accepted transaction");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a transaction");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.point_x == '0 && rsp_data.point_y == '0 && rsp_data.point_z == '0))
      else $error("miss with nonzero point");

endmodule

bind ray_box_intersection_unit rbi_checker u_rbi_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
